>>> rtl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared constants, widths and codes of the fixed block free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

    localparam int MAX_BLOCKS   = 1024;
    localparam int ADDRESS_BITS = 48;

    localparam int FIELD_W  = 48;
    localparam int ADDR_W   = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;
    localparam bit SPAN_LIMIT = (ADDRESS_BITS <= FIELD_W);

    localparam int SIZE_W   = 21;
    localparam int COUNT_W  = 11;
    localparam int TOT_W    = SIZE_W + COUNT_W;
    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int LINK_W   = IDX_W + 1;
    localparam int MUL_IDX_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
    localparam int PROD_W   = MUL_IDX_W + SIZE_W;
    localparam int DIV_CNT_W = $clog2(TOT_W);

    localparam int ACT_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [ACT_W-1:0] ACT_GET    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RETURN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INIT   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INIT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 21'd4096;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

endpackage

`default_nettype wire

>>> rtl/fbfl_ram.sv
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/fbfl_div.sv
// ----------------------------------------------------------------------------
// fbfl_div
// Restoring divider, one quotient bit per cycle, for byte offset by block size.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [fbfl_pkg::TOT_W-1:0]  dividend,
    input  wire logic [fbfl_pkg::SIZE_W-1:0] divisor,
    output logic                             done,
    output logic      [fbfl_pkg::TOT_W-1:0]  quotient,
    output logic      [fbfl_pkg::SIZE_W-1:0] remainder
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [fbfl_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [fbfl_pkg::TOT_W-1:0]       quo_reg;
    logic [fbfl_pkg::SIZE_W-1:0]      rem_reg;
    logic [fbfl_pkg::SIZE_W-1:0]      dvs_reg;

    logic [fbfl_pkg::SIZE_W:0]        shifted;
    logic [fbfl_pkg::SIZE_W+1:0]      diff;
    logic                             fits;

    assign shifted = {rem_reg, quo_reg[fbfl_pkg::TOT_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !diff[fbfl_pkg::SIZE_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= fbfl_pkg::DIV_CNT_W'(fbfl_pkg::TOT_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - fbfl_pkg::DIV_CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[fbfl_pkg::TOT_W-2:0], fits};
            rem_reg <= fits ? diff[fbfl_pkg::SIZE_W-1:0] : shifted[fbfl_pkg::SIZE_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of equal-sized blocks with a LIFO stack of returned blocks held in RAM.
// ----------------------------------------------------------------------------
// init runs MUL, CHK; get SEL, LINK if stacked, MUL, ADD; return CHK, DIV if in range
// one request at a time; the next one is accepted after the result registers
// a return that passes the range check then goes through the serial divider
// a finished result waits in the output register while the next request enters
// reset clears the pool to not ready; links RAM is not cleared, valid by use
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fbfl_pkg::FIELD_W-1:0]   cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [fbfl_pkg::FIELD_W-1:0]   s_tdata,   // address_in
    input  wire logic [fbfl_pkg::ACT_W-1:0]     s_tuser,   // action
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [fbfl_pkg::FIELD_W-1:0]   m_tdata,   // address_out
    output logic      [fbfl_pkg::STATUS_W-1:0]  m_tuser    // status
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_INIT_MUL = 4'd1;
    localparam logic [3:0] ST_INIT_CHK = 4'd2;
    localparam logic [3:0] ST_GET_SEL  = 4'd3;
    localparam logic [3:0] ST_GET_LINK = 4'd4;
    localparam logic [3:0] ST_GET_MUL  = 4'd5;
    localparam logic [3:0] ST_GET_ADD  = 4'd6;
    localparam logic [3:0] ST_RET_CHK  = 4'd7;
    localparam logic [3:0] ST_RET_DIV  = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    logic [3:0]                           state_reg;

    logic [fbfl_pkg::FIELD_W-1:0]         cfg_base_reg;
    logic [fbfl_pkg::SIZE_W-1:0]          cfg_size_reg;
    logic [fbfl_pkg::COUNT_W-1:0]         cfg_count_reg;

    logic                                 pool_ready_reg;
    logic                                 nonempty_reg;
    logic [fbfl_pkg::IDX_W-1:0]           head_reg;
    logic [fbfl_pkg::COUNT_W-1:0]         next_reg;
    logic [fbfl_pkg::ADDR_W-1:0]          pool_base_reg;
    logic [fbfl_pkg::SIZE_W-1:0]          pool_size_reg;
    logic [fbfl_pkg::COUNT_W-1:0]         pool_count_reg;
    logic [fbfl_pkg::TOT_W-1:0]           pool_total_reg;

    logic [fbfl_pkg::ACT_W-1:0]           act_reg;
    logic [fbfl_pkg::ADDR_W-1:0]          addr_reg;
    logic [fbfl_pkg::MUL_IDX_W-1:0]       idx_reg;
    logic [fbfl_pkg::PROD_W-1:0]          prod_reg;
    logic [fbfl_pkg::ADDR_W-1:0]          res_addr_reg;
    logic [fbfl_pkg::STATUS_W-1:0]        res_status_reg;

    logic                                 m_valid_reg;
    logic [fbfl_pkg::FIELD_W-1:0]         m_data_reg;
    logic [fbfl_pkg::STATUS_W-1:0]        m_user_reg;

    logic                                 in_fire;
    logic                                 out_free;
    logic [fbfl_pkg::ADDR_W-1:0]          cfg_base_eff;
    logic [fbfl_pkg::ADDR_W:0]            init_sum;
    logic                                 init_bad;
    logic [fbfl_pkg::ADDR_W-1:0]          ret_off;
    logic                                 ret_bad;

    logic                                 mem_we;
    logic [fbfl_pkg::IDX_W-1:0]           mem_waddr;
    logic [fbfl_pkg::LINK_W-1:0]          mem_wdata;
    logic                                 mem_re;
    logic [fbfl_pkg::LINK_W-1:0]          mem_rdata;

    logic                                 div_start;
    logic                                 div_done;
    logic [fbfl_pkg::TOT_W-1:0]           div_quo;
    logic [fbfl_pkg::SIZE_W-1:0]          div_rem;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign cfg_base_eff = cfg_base_reg[fbfl_pkg::ADDR_W-1:0];
    assign init_sum = {1'b0, cfg_base_eff} + (fbfl_pkg::ADDR_W+1)'(pool_total_reg);
    assign init_bad = (cfg_base_eff == '0) || (cfg_size_reg == '0) || (cfg_count_reg == '0)
                   || (32'(cfg_count_reg) > 32'(fbfl_pkg::MAX_BLOCKS))
                   || (fbfl_pkg::SPAN_LIMIT && init_sum[fbfl_pkg::ADDR_W]
                       && (init_sum[fbfl_pkg::ADDR_W-1:0] != '0));

    assign ret_off = addr_reg - pool_base_reg;
    assign ret_bad = !pool_ready_reg || (addr_reg < pool_base_reg)
                  || (ret_off >= fbfl_pkg::ADDR_W'(pool_total_reg));

    assign div_start = (state_reg == ST_RET_CHK) && !ret_bad;

    assign mem_re    = (state_reg == ST_GET_SEL) && pool_ready_reg && nonempty_reg;
    assign mem_we    = (state_reg == ST_RET_DIV) && div_done && (div_rem == '0);
    assign mem_waddr = div_quo[fbfl_pkg::IDX_W-1:0];
    assign mem_wdata = nonempty_reg ? {1'b0, head_reg} : {1'b1, {fbfl_pkg::IDX_W{1'b0}}};

    fbfl_ram #(
        .WIDTH (fbfl_pkg::LINK_W),
        .DEPTH (fbfl_pkg::MAX_BLOCKS)
    ) u_links (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    fbfl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (ret_off[fbfl_pkg::TOT_W-1:0]),
        .divisor   (pool_size_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cfg_base_reg   <= '0;
            cfg_size_reg   <= fbfl_pkg::SIZE_RESET;
            cfg_count_reg  <= fbfl_pkg::COUNT_RESET;
            pool_ready_reg <= 1'b0;
            nonempty_reg   <= 1'b0;
            head_reg       <= '0;
            next_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    fbfl_pkg::REG_BASE:  cfg_base_reg  <= cfg_wdata;
                    fbfl_pkg::REG_SIZE:  cfg_size_reg  <= cfg_wdata[fbfl_pkg::SIZE_W-1:0];
                    fbfl_pkg::REG_COUNT: cfg_count_reg <= cfg_wdata[fbfl_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end

            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        case (s_tuser)
                            fbfl_pkg::ACT_INIT:   state_reg <= ST_INIT_MUL;
                            fbfl_pkg::ACT_GET:    state_reg <= ST_GET_SEL;
                            fbfl_pkg::ACT_RETURN: state_reg <= ST_RET_CHK;
                            default:              state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_INIT_MUL: state_reg <= ST_INIT_CHK;
                ST_INIT_CHK: begin
                    pool_ready_reg <= !init_bad;
                    nonempty_reg   <= 1'b0;
                    head_reg       <= '0;
                    next_reg       <= '0;
                    state_reg      <= ST_DONE;
                end
                ST_GET_SEL: begin
                    if (!pool_ready_reg) begin
                        state_reg <= ST_DONE;
                    end else if (nonempty_reg) begin
                        state_reg <= ST_GET_LINK;
                    end else if (next_reg < pool_count_reg) begin
                        next_reg  <= next_reg + fbfl_pkg::COUNT_W'(1);
                        state_reg <= ST_GET_MUL;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_GET_LINK: begin
                    if (mem_rdata[fbfl_pkg::IDX_W]) begin
                        nonempty_reg <= 1'b0;
                    end else begin
                        head_reg <= mem_rdata[fbfl_pkg::IDX_W-1:0];
                    end
                    state_reg <= ST_GET_MUL;
                end
                ST_GET_MUL: state_reg <= ST_GET_ADD;
                ST_GET_ADD: state_reg <= ST_DONE;
                ST_RET_CHK: state_reg <= ret_bad ? ST_DONE : ST_RET_DIV;
                ST_RET_DIV: begin
                    if (div_done) begin
                        if (div_rem == '0) begin
                            head_reg     <= mem_waddr;
                            nonempty_reg <= 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    act_reg        <= s_tuser;
                    addr_reg       <= s_tdata[fbfl_pkg::ADDR_W-1:0];
                    res_addr_reg   <= '0;
                    res_status_reg <= fbfl_pkg::STATUS_OK;
                end
            end
            ST_INIT_MUL: begin
                pool_total_reg <= fbfl_pkg::TOT_W'(cfg_size_reg)
                                * fbfl_pkg::TOT_W'(cfg_count_reg);
            end
            ST_INIT_CHK: begin
                pool_base_reg  <= cfg_base_eff;
                pool_size_reg  <= cfg_size_reg;
                pool_count_reg <= cfg_count_reg;
                if (init_bad) begin
                    res_status_reg <= fbfl_pkg::STATUS_BAD_INIT;
                end
            end
            ST_GET_SEL: begin
                if (nonempty_reg) begin
                    idx_reg <= fbfl_pkg::MUL_IDX_W'(head_reg);
                end else begin
                    idx_reg <= fbfl_pkg::MUL_IDX_W'(next_reg);
                end
                if (!pool_ready_reg || (!nonempty_reg && !(next_reg < pool_count_reg))) begin
                    res_status_reg <= fbfl_pkg::STATUS_EMPTY;
                end
            end
            ST_GET_MUL: begin
                prod_reg <= fbfl_pkg::PROD_W'(idx_reg) * fbfl_pkg::PROD_W'(pool_size_reg);
            end
            ST_GET_ADD: begin
                res_addr_reg <= pool_base_reg + fbfl_pkg::ADDR_W'(prod_reg);
            end
            ST_RET_CHK: begin
                if (ret_bad) begin
                    res_status_reg <= fbfl_pkg::STATUS_BAD_ADDR;
                end
            end
            ST_RET_DIV: begin
                if (div_done && (div_rem != '0)) begin
                    res_status_reg <= fbfl_pkg::STATUS_BAD_ADDR;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg <= fbfl_pkg::FIELD_W'(res_addr_reg);
                    m_user_reg <= res_status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_stack_needs_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        !pool_ready_reg |-> !nonempty_reg)
        else $error("free stack holds a block while the pool is not ready");

    a_untouched_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pool_ready_reg |-> (next_reg <= pool_count_reg))
        else $error("untouched block index ran past the pool");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("request accepted while the previous one is in progress");

    a_write_on_return: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (act_reg == fbfl_pkg::ACT_RETURN) && pool_ready_reg)
        else $error("links written outside a valid return");

endmodule

`default_nettype wire
